/* hdl/chacha_pkg.sv */
`default_nettype none
package chacha_pkg;

    // ChaCha20 state constants ("expand 32-byte k")
    localparam logic [3:0][31:0] SIGMA = {
        32'h6b206574, 32'h79622d32, 32'h3320646e, 32'h61707865
    };

    // Configuration register indexes (paddr[5:3])
    localparam logic [2:0] REG_KEY_A         = 3'd0;
    localparam logic [2:0] REG_KEY_B         = 3'd1;
    localparam logic [2:0] REG_KEY_C         = 3'd2;
    localparam logic [2:0] REG_KEY_D         = 3'd3;
    localparam logic [2:0] REG_NONCE_LOW     = 3'd4;
    localparam logic [2:0] REG_NONCE_HIGH    = 3'd5;
    localparam logic [2:0] REG_START_COUNTER = 3'd6;

    // Rounds are counted in half rounds (column, then diagonal)
    localparam int          HALF_ROUNDS = 20;
    localparam logic [4:0]  LAST_HALF   = 5'(HALF_ROUNDS - 1);

    typedef struct packed {
        logic [31:0] data_in;
        logic [2:0]  byte_count;
        logic        last;
    } in_item_t;

    typedef struct packed {
        logic [31:0] data_out;
        logic [2:0]  byte_count_out;
        logic        last_out;
    } out_item_t;

    // Everything the block function needs besides the constants
    typedef struct packed {
        logic [7:0][31:0] key;
        logic [31:0]      counter;
        logic [2:0][31:0] nonce;
    } block_in_t;

    // Rotate left by the amount that belongs to each quarter-round step
    function automatic logic [31:0] step_rotl(input logic [31:0] v, input logic [1:0] step);
        logic [31:0] r;
        case (step)
            2'd0:    r = {v[15:0], v[31:16]};
            2'd1:    r = {v[19:0], v[31:20]};
            2'd2:    r = {v[23:0], v[31:24]};
            default: r = {v[24:0], v[31:25]};
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

/* hdl/chacha_core.sv */
`default_nettype none
module chacha_core
    import chacha_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire block_in_t   block_in,
    input  wire logic [3:0]  word_idx,
    output logic             done,
    output logic [31:0]      word_out
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ROUND,
        ST_FINAL
    } core_state_t;

    core_state_t state_reg;
    logic [1:0]  step_reg;
    logic [4:0]  half_reg;
    logic        done_reg;

    logic [31:0] words_reg  [16];
    logic [31:0] words_next [16];
    logic [31:0] init_words [16];

    logic [3:0]  x_idx [4];
    logic [3:0]  z_idx [4];
    logic [31:0] opy   [4];
    logic [31:0] sum   [4];
    logic [31:0] z_new [4];

    // Build the input state from constants, key, counter and nonce
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            init_words[i] = SIGMA[i];
        end
        for (int i = 0; i < 8; i++)
        begin
            init_words[4 + i] = block_in.key[i];
        end
        init_words[12] = block_in.counter;
        for (int i = 0; i < 3; i++)
        begin
            init_words[13 + i] = block_in.nonce[i];
        end
    end

    // Four lanes of one add-xor-rotate step each; odd half rounds run the diagonals
    always_comb
    begin
        logic [1:0] ln;
        logic [3:0] ia, ib, ic, id;
        logic       diag;
        diag = half_reg[0];
        for (int l = 0; l < 4; l++)
        begin
            ln = 2'(l);
            ia = {2'd0, ln};
            ib = {2'd1, 2'(ln + (diag ? 2'd1 : 2'd0))};
            ic = {2'd2, 2'(ln + (diag ? 2'd2 : 2'd0))};
            id = {2'd3, 2'(ln + (diag ? 2'd3 : 2'd0))};
            if (state_reg == ST_FINAL)
            begin
                // Add the input state back, one row per cycle
                x_idx[l] = {step_reg, ln};
                z_idx[l] = {step_reg, ln};
                opy[l]   = init_words[{step_reg, ln}];
            end
            else if (!step_reg[0])
            begin
                x_idx[l] = ia;
                z_idx[l] = id;
                opy[l]   = words_reg[ib];
            end
            else
            begin
                x_idx[l] = ic;
                z_idx[l] = ib;
                opy[l]   = words_reg[id];
            end
            sum[l]   = words_reg[x_idx[l]] + opy[l];
            z_new[l] = step_rotl(words_reg[z_idx[l]] ^ sum[l], step_reg);
        end
    end

    // Select the next working words
    always_comb
    begin
        for (int i = 0; i < 16; i++)
        begin
            words_next[i] = words_reg[i];
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    for (int i = 0; i < 16; i++)
                    begin
                        words_next[i] = init_words[i];
                    end
                end
            end
            ST_ROUND:
            begin
                for (int l = 0; l < 4; l++)
                begin
                    words_next[x_idx[l]] = sum[l];
                    words_next[z_idx[l]] = z_new[l];
                end
            end
            ST_FINAL:
            begin
                for (int l = 0; l < 4; l++)
                begin
                    words_next[x_idx[l]] = sum[l];
                end
            end
            default:
            begin
            end
        endcase
    end

    // Hold the working words
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 16; i++)
        begin
            words_reg[i] <= words_next[i];
        end
    end

    // Sequence steps, half rounds and the final add
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= 2'd0;
            half_reg  <= 5'd0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    step_reg <= 2'd0;
                    half_reg <= 5'd0;
                    if (start)
                    begin
                        state_reg <= ST_ROUND;
                    end
                end
                ST_ROUND:
                begin
                    step_reg <= step_reg + 2'd1;
                    if (step_reg == 2'd3)
                    begin
                        if (half_reg == LAST_HALF)
                        begin
                            state_reg <= ST_FINAL;
                        end
                        else
                        begin
                            half_reg <= half_reg + 5'd1;
                        end
                    end
                end
                ST_FINAL:
                begin
                    step_reg <= step_reg + 2'd1;
                    if (step_reg == 2'd3)
                    begin
                        state_reg <= ST_IDLE;
                        done_reg  <= 1'b1;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign done     = done_reg;
    assign word_out = words_reg[word_idx];

endmodule
`default_nettype wire

/* hdl/chacha20_stream_cipher.sv */
`default_nettype none
// ChaCha20 stream cipher, one 32-bit message word per request.
// Input channel (in_valid/in_ready/in_data) carries a word, its byte count
// and a last flag; the output channel (out_valid/out_ready/out_data) returns
// the word XORed with the keystream, unused bytes zeroed, count capped at 4, flag kept.
// Key, nonce and start counter are written over the APB port (8-byte slots,
// paddr[5:3] selects the register); the user must write them only while no
// request is in flight, as the block itself does not enforce this.
// A word that uses the current keystream block goes from acceptance through the
// emit state into the output register. A word that needs a new block
// (the first of each 16-word block and the first word of each message) waits
// for the shared four-lane quarter-round unit: the start state loads it, it
// runs 20 rounds of steps and the add-back of the input state, the wait state
// sees done, and the emit state then writes the word into the output register.
// in_ready is high only while the block waits for a new request.
// Reset clears the control and configuration registers and counters; the first word
// after reset or a last word starts a new message at the configured start counter.
// A stalled receiver holds the result in the output register; the block still
// accepts the next request and waits before writing its result.
module chacha20_stream_cipher
    import chacha_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire in_item_t    in_data,
    output logic             out_valid,
    input  wire logic        out_ready,
    output out_item_t        out_data,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [5:0]  paddr,
    input  wire logic [63:0] pwdata,
    output logic [63:0]      prdata,
    output logic             pready
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_START,
        ST_WAIT,
        ST_EMIT
    } top_state_t;

    top_state_t  state_reg;
    in_item_t    item_reg;
    logic [31:0] block_counter_reg;
    logic [3:0]  word_pos_reg;
    logic        need_block_reg;
    logic        started_reg;
    logic        out_valid_reg;
    out_item_t   out_data_reg;

    logic [63:0] key_a_reg, key_b_reg, key_c_reg, key_d_reg, nonce_low_reg;
    logic [31:0] nonce_high_reg, start_counter_reg;

    logic        cfg_write;
    logic [2:0]  cfg_idx;
    block_in_t   block_in;
    logic        core_done;
    logic [31:0] ks_word;
    logic [2:0]  count_clamped;
    logic [31:0] keep_mask;
    logic        out_free;

    // Configuration port
    assign pready    = 1'b1;
    assign cfg_idx   = paddr[5:3];
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_a_reg         <= '0;
            key_b_reg         <= '0;
            key_c_reg         <= '0;
            key_d_reg         <= '0;
            nonce_low_reg     <= '0;
            nonce_high_reg    <= '0;
            start_counter_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_idx)
                REG_KEY_A:         key_a_reg         <= pwdata;
                REG_KEY_B:         key_b_reg         <= pwdata;
                REG_KEY_C:         key_c_reg         <= pwdata;
                REG_KEY_D:         key_d_reg         <= pwdata;
                REG_NONCE_LOW:     nonce_low_reg     <= pwdata;
                REG_NONCE_HIGH:    nonce_high_reg    <= pwdata[31:0];
                REG_START_COUNTER: start_counter_reg <= pwdata[31:0];
                default:
                begin
                end
            endcase
        end
    end

    // Return register contents on reads
    always_comb
    begin
        case (cfg_idx)
            REG_KEY_A:         prdata = key_a_reg;
            REG_KEY_B:         prdata = key_b_reg;
            REG_KEY_C:         prdata = key_c_reg;
            REG_KEY_D:         prdata = key_d_reg;
            REG_NONCE_LOW:     prdata = nonce_low_reg;
            REG_NONCE_HIGH:    prdata = {32'd0, nonce_high_reg};
            REG_START_COUNTER: prdata = {32'd0, start_counter_reg};
            default:           prdata = 64'd0;
        endcase
    end

    // Feed the block function
    assign block_in.key     = {key_d_reg, key_c_reg, key_b_reg, key_a_reg};
    assign block_in.counter = block_counter_reg;
    assign block_in.nonce   = {nonce_high_reg, nonce_low_reg};

    chacha_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (state_reg == ST_START),
        .block_in (block_in),
        .word_idx (word_pos_reg),
        .done     (core_done),
        .word_out (ks_word)
    );

    // Clamp the byte count and mask the unused bytes
    always_comb
    begin
        count_clamped = (item_reg.byte_count > 3'd4) ? 3'd4 : item_reg.byte_count;
        case (count_clamped)
            3'd0:    keep_mask = 32'h0000_0000;
            3'd1:    keep_mask = 32'h0000_00ff;
            3'd2:    keep_mask = 32'h0000_ffff;
            3'd3:    keep_mask = 32'h00ff_ffff;
            default: keep_mask = 32'hffff_ffff;
        endcase
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Hold the result payload
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && in_valid)
        begin
            item_reg <= in_data;
        end
        if (state_reg == ST_EMIT && out_free)
        begin
            out_data_reg.data_out       <= (item_reg.data_in ^ ks_word) & keep_mask;
            out_data_reg.byte_count_out <= count_clamped;
            out_data_reg.last_out       <= item_reg.last;
        end
    end

    // Sequence each request: new message, new block, emit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            block_counter_reg <= '0;
            word_pos_reg      <= '0;
            need_block_reg    <= 1'b1;
            started_reg       <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        if (!started_reg)
                        begin
                            block_counter_reg <= start_counter_reg;
                            word_pos_reg      <= 4'd0;
                            started_reg       <= 1'b1;
                            state_reg         <= ST_START;
                        end
                        else if (need_block_reg)
                        begin
                            state_reg <= ST_START;
                        end
                        else
                        begin
                            state_reg <= ST_EMIT;
                        end
                    end
                end
                ST_START:
                begin
                    state_reg <= ST_WAIT;
                end
                ST_WAIT:
                begin
                    if (core_done)
                    begin
                        block_counter_reg <= block_counter_reg + 32'd1;
                        need_block_reg    <= 1'b0;
                        state_reg         <= ST_EMIT;
                    end
                end
                ST_EMIT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        word_pos_reg  <= word_pos_reg + 4'd1;
                        if (word_pos_reg == 4'd15)
                        begin
                            need_block_reg <= 1'b1;
                        end
                        if (item_reg.last)
                        begin
                            started_reg <= 1'b0;
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire
